// File: rtl/core/sts_pkg.sv
`default_nettype none

package sts_pkg;

   // Function codes of an input item.
   localparam logic [2:0] FUNC_READ_WORD  = 3'd0;
   localparam logic [2:0] FUNC_WRITE_WORD = 3'd1;
   localparam logic [2:0] FUNC_SET_BIT    = 3'd2;
   localparam logic [2:0] FUNC_CLEAR_BIT  = 3'd3;
   localparam logic [2:0] FUNC_TEST_BIT   = 3'd4;

   // Fixed field widths of the two channels.
   localparam int FUNC_W   = 3;
   localparam int ADDR_W   = 20;
   localparam int WORD_W   = 32;
   localparam int BITOFF_W = 5;

   // Queue between the lookup front and the page back.
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = 1;
   localparam int QUEUE_COUNT_W = 2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [ADDR_W-1:0]   addr;
      logic [WORD_W-1:0]   wdata;
      logic [BITOFF_W-1:0] bit_offset;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] rdata;
      logic              bit_value;
      logic              out_of_memory;
   } rsp_type;

   // Classified operation handed from the front to the back.
   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic                page_hit;
      logic                out_of_memory;
      logic [WORD_W-1:0]   wdata;
      logic [BITOFF_W-1:0] bit_offset;
   } op_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/sts_ram.sv
`default_nettype none

module sts_ram import sts_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/sts_queue.sv
`default_nettype none

module sts_queue import sts_pkg::*; #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0]         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/sts_front.sv
`default_nettype none

module sts_front import sts_pkg::*; #(
   parameter int DIR_INDEX_BITS   = 10,
   parameter int PAGE_OFFSET_BITS = 10,
   parameter int POOL_PAGES       = 64,
   localparam int EW      = $clog2(POOL_PAGES + 1),
   localparam int PIDX_W  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1,
   localparam int PW_DEPTH = POOL_PAGES * (1 << PAGE_OFFSET_BITS),
   localparam int PA_W    = (PW_DEPTH > 1) ? $clog2(PW_DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire req_type           req_data,
   output logic                   full,
   output logic                   q_push,
   output op_ctrl_type            q_ctrl,
   output logic      [PA_W-1:0]   q_addr,
   input  wire logic              q_full
);

   localparam int DIR_DEPTH = 1 << DIR_INDEX_BITS;

   logic                        clear_ff, clear_in;
   logic [DIR_INDEX_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic                        busy_ff, busy_in;
   req_type                     item_ff, item_in;
   logic [EW-1:0]               pages_used_ff, pages_used_in;

   logic                        accept;
   logic [31:0]                 req_addr_ext, item_addr_ext;
   logic [DIR_INDEX_BITS-1:0]   req_index, item_index;
   logic [PAGE_OFFSET_BITS-1:0] item_offset;
   logic [EW-1:0]               entry, entry_eff, entry_less;
   logic                        entry_zero, is_write, is_read, pool_empty, alloc, oom;
   logic [PIDX_W-1:0]           page_index;
   logic                        dir_wr_en;
   logic [DIR_INDEX_BITS-1:0]   dir_wr_addr;
   logic [EW-1:0]               dir_wr_data;
   logic [EW-1:0]               dir_rd_data_w;

   // Address split; bits above the directory index are dropped.
   assign req_addr_ext  = {{(32 - ADDR_W){1'b0}}, req_data.addr};
   assign item_addr_ext = {{(32 - ADDR_W){1'b0}}, item_ff.addr};
   assign req_index     = req_addr_ext[PAGE_OFFSET_BITS +: DIR_INDEX_BITS];
   assign item_index    = item_addr_ext[PAGE_OFFSET_BITS +: DIR_INDEX_BITS];
   assign item_offset   = item_addr_ext[PAGE_OFFSET_BITS-1:0];

   // One item at a time: lookup in the cycle after accept, then hand off.
   assign full   = clear_ff | busy_ff;
   assign accept = push & ~full;
   assign q_push = busy_ff & ~q_full;

   // Classify the item against its directory entry and allocate a page.
   always_comb begin
      entry      = dir_rd_data_w;
      entry_zero = (entry == '0);
      is_write   = (item_ff.func == FUNC_WRITE_WORD) || (item_ff.func == FUNC_SET_BIT) ||
                   (item_ff.func == FUNC_CLEAR_BIT);
      is_read    = (item_ff.func == FUNC_READ_WORD) || (item_ff.func == FUNC_TEST_BIT);
      pool_empty = (pages_used_ff >= EW'(POOL_PAGES));
      alloc      = is_write & entry_zero & ~pool_empty;
      oom        = is_write & entry_zero & pool_empty;
      entry_eff  = alloc ? pages_used_ff + EW'(1) : entry;
      entry_less = entry_eff - EW'(1);
      page_index = entry_less[PIDX_W-1:0];
   end

   always_comb begin
      q_ctrl.func          = item_ff.func;
      q_ctrl.page_hit      = is_read ? ~entry_zero : (is_write & ~oom);
      q_ctrl.out_of_memory = oom;
      q_ctrl.wdata         = item_ff.wdata;
      q_ctrl.bit_offset    = item_ff.bit_offset;
      q_addr               = PA_W'({page_index, item_offset});
   end

   // Directory write: clearing pass after reset, else a new page mapping.
   always_comb begin
      dir_wr_en   = clear_ff | (q_push & alloc);
      dir_wr_addr = clear_ff ? clr_addr_ff : item_index;
      dir_wr_data = clear_ff ? '0 : entry_eff;
   end

   sts_ram #(
      .WIDTH (EW),
      .DEPTH (DIR_DEPTH)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr_en),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_en   (accept),
      .rd_addr (req_index),
      .rd_data (dir_rd_data_w)
   );

   // Control state update.
   always_comb begin
      clear_in      = clear_ff;
      clr_addr_in   = clr_addr_ff;
      busy_in       = busy_ff;
      item_in       = item_ff;
      pages_used_in = pages_used_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + DIR_INDEX_BITS'(1);
         if (clr_addr_ff == '1) begin
            clear_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         item_in = req_data;
      end else if (q_push) begin
         busy_in = 1'b0;
      end
      if (q_push && alloc) begin
         pages_used_in = entry_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clr_addr_ff   <= '0;
         busy_ff       <= 1'b0;
         pages_used_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clr_addr_ff   <= clr_addr_in;
         busy_ff       <= busy_in;
         pages_used_ff <= pages_used_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/sts_back.sv
`default_nettype none

module sts_back import sts_pkg::*; #(
   parameter int PAGE_OFFSET_BITS = 10,
   parameter int POOL_PAGES       = 64,
   localparam int PW_DEPTH = POOL_PAGES * (1 << PAGE_OFFSET_BITS),
   localparam int PA_W     = (PW_DEPTH > 1) ? $clog2(PW_DEPTH) : 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_empty,
   input  wire op_ctrl_type     q_ctrl,
   input  wire logic [PA_W-1:0] q_addr,
   output logic                 q_pop,
   output logic                 empty,
   input  wire logic            pop,
   output rsp_type              rsp_data
);

   logic              clear_ff, clear_in;
   logic [PA_W-1:0]   clr_addr_ff, clr_addr_in;
   logic              exec_ff, exec_in;
   op_ctrl_type       ctrl_ff, ctrl_in;
   logic [PA_W-1:0]   addr_ff, addr_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              done, is_write;
   logic [WORD_W-1:0] page_rd_data, word, mask, new_word;
   logic              pw_wr_en;
   logic [PA_W-1:0]   pw_wr_addr;
   logic [WORD_W-1:0] pw_wr_data;
   rsp_type           result;

   // Take an item only when no read-modify-write is in flight.
   assign q_pop = ~clear_ff & ~exec_ff & ~q_empty;
   assign done  = exec_ff & (~out_valid_ff | pop);
   assign empty = ~out_valid_ff;
   assign rsp_data = out_ff;

   // Modify the addressed word and form the result.
   always_comb begin
      word     = ctrl_ff.page_hit ? page_rd_data : '0;
      mask     = WORD_W'(1) << ctrl_ff.bit_offset;
      is_write = 1'b0;
      new_word = word;
      case (ctrl_ff.func)
         FUNC_WRITE_WORD: begin
            is_write = 1'b1;
            new_word = ctrl_ff.wdata;
         end
         FUNC_SET_BIT: begin
            is_write = 1'b1;
            new_word = word | mask;
         end
         FUNC_CLEAR_BIT: begin
            is_write = 1'b1;
            new_word = word & ~mask;
         end
         default: begin
            is_write = 1'b0;
         end
      endcase
      result.rdata = ((ctrl_ff.func == FUNC_READ_WORD) || (ctrl_ff.func == FUNC_TEST_BIT)) ?
                     word : '0;
      result.bit_value     = (ctrl_ff.func == FUNC_TEST_BIT) ? word[ctrl_ff.bit_offset] : 1'b0;
      result.out_of_memory = ctrl_ff.out_of_memory;
   end

   // Page memory write: clearing pass after reset, else the modified word.
   always_comb begin
      pw_wr_en   = clear_ff | (done & is_write & ctrl_ff.page_hit);
      pw_wr_addr = clear_ff ? clr_addr_ff : addr_ff;
      pw_wr_data = clear_ff ? '0 : new_word;
   end

   sts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PW_DEPTH)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (pw_wr_en),
      .wr_addr (pw_wr_addr),
      .wr_data (pw_wr_data),
      .rd_en   (q_pop),
      .rd_addr (q_addr),
      .rd_data (page_rd_data)
   );

   // Control state update.
   always_comb begin
      clear_in     = clear_ff;
      clr_addr_in  = clr_addr_ff;
      exec_in      = exec_ff;
      ctrl_in      = ctrl_ff;
      addr_in      = addr_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + PA_W'(1);
         if (clr_addr_ff == PA_W'(PW_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
      if (q_pop) begin
         exec_in = 1'b1;
         ctrl_in = q_ctrl;
         addr_in = q_addr;
      end else if (done) begin
         exec_in = 1'b0;
      end
      if (done) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         exec_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         exec_ff      <= exec_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      addr_ff <= addr_in;
      out_ff  <= out_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/sparse_two_level_shadow_tag_store_core.sv
`default_nettype none

// Channel    Ports                         Accepted when
// input      push, full, req_data          push high and full low
// result     empty, pop, rsp_data          pop high and empty low
//
// Each half works on one item at a time: a directory read then the page mapping
// in the front, a page word read then its write-back in the back; finishing each
// read-modify-write before the next read avoids forwarding, and neither half
// takes a new item before it is through with the last one.
// After reset the page memory is cleared one word a cycle, all POOL_PAGES times
// 2^PAGE_OFFSET_BITS words, and the directory likewise, all 2^DIR_INDEX_BITS entries;
// full stays high until the directory is clear, and items taken before the page
// memory is clear wait in the queue. A two-entry queue and the result register
// let either side stall without losing an item.

module sparse_two_level_shadow_tag_store_core import sts_pkg::*; #(
   parameter int DIR_INDEX_BITS   = 10,
   parameter int PAGE_OFFSET_BITS = 10,
   parameter int POOL_PAGES       = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   localparam int PW_DEPTH = POOL_PAGES * (1 << PAGE_OFFSET_BITS);
   localparam int PA_W     = (PW_DEPTH > 1) ? $clog2(PW_DEPTH) : 1;
   localparam int QW       = $bits(op_ctrl_type) + PA_W;

   logic              fq_push, fq_full, bq_pop, bq_empty;
   op_ctrl_type       fq_ctrl, bq_ctrl;
   logic [PA_W-1:0]   fq_addr, bq_addr;
   logic [QW-1:0]     bq_data;

   // Lookup and page allocation.
   sts_front #(
      .DIR_INDEX_BITS   (DIR_INDEX_BITS),
      .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
      .POOL_PAGES       (POOL_PAGES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .q_push   (fq_push),
      .q_ctrl   (fq_ctrl),
      .q_addr   (fq_addr),
      .q_full   (fq_full)
   );

   // Decoupling queue.
   sts_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data ({fq_ctrl, fq_addr}),
      .full      (fq_full),
      .pop       (bq_pop),
      .pop_data  (bq_data),
      .empty     (bq_empty)
   );

   assign bq_ctrl = bq_data[QW-1:PA_W];
   assign bq_addr = bq_data[PA_W-1:0];

   // Page word read-modify-write and result register.
   sts_back #(
      .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
      .POOL_PAGES       (POOL_PAGES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (bq_empty),
      .q_ctrl   (bq_ctrl),
      .q_addr   (bq_addr),
      .q_pop    (bq_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
